// ===== rtl/kbd_pkg.sv =====
// Package for the keyed byte descrambler: item types, key table, encoding codes.
// Used by every module of the block; depends on nothing.
`timescale 1ns / 1ps

package kbd_pkg;

	localparam int KEY_LENGTH = 32;
	localparam int KEY_IDX_W  = (KEY_LENGTH > 1) ? $clog2(KEY_LENGTH) : 1;
	localparam int KEY_TABLE_LEN = 32;

	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	localparam logic [7:0] ADD_BIAS    = 8'd106;
	localparam logic [7:0] FINAL_SUB   = 8'd27;
	localparam logic [7:0] STEP_FIVE   = 8'd2;
	localparam logic [7:0] STEP_SEVEN  = 8'd9;
	localparam logic [7:0] STEP_THREE  = 8'd3;
	localparam logic [7:0] BOM16_FIRST = 8'd255;
	localparam logic [7:0] BOM16_SEC   = 8'd254;
	localparam logic [7:0] BOM8_FIRST  = 8'd239;
	localparam logic [7:0] BOM8_SEC    = 8'd187;
	localparam logic [7:0] BOM8_THIRD  = 8'd191;

	typedef enum logic [1:0] {
		GUESS_CP1252 = 2'd0,
		GUESS_UTF16  = 2'd1,
		GUESS_UTF8   = 2'd2
	} guess_t;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       last_byte;
	} in_item_t;

	typedef struct packed {
		logic [7:0] plain_byte;
		logic [1:0] encoding_guess;
		logic       guess_final;
		logic       last_out;
	} out_item_t;

	typedef struct packed {
		logic [7:0] plain;
		logic       last;
	} q_entry_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_status_t;

	typedef logic [7:0] key_rom_t [KEY_TABLE_LEN];

	localparam key_rom_t KEY_ROM = '{
		8'd66, 8'd67, 8'd51, 8'd55, 8'd51, 8'd65, 8'd67, 8'd65,
		8'd50, 8'd55, 8'd57, 8'd50, 8'd52, 8'd69, 8'd66, 8'd69,
		8'd65, 8'd50, 8'd57, 8'd68, 8'd50, 8'd65, 8'd50, 8'd50,
		8'd69, 8'd51, 8'd52, 8'd56, 8'd65, 8'd67, 8'd66, 8'd52
	};

	function automatic logic [7:0] key_byte(input logic [KEY_IDX_W-1:0] idx);
		logic [4:0] i5;
		i5 = 5'(idx);
		return KEY_ROM[i5];
	endfunction

	function automatic guess_t guess_of(input logic [7:0] b0, input logic [7:0] b1,
			input logic [7:0] b2);
		guess_t g;
		if (b0 == BOM16_FIRST && b1 == BOM16_SEC)
			g = GUESS_UTF16;
		else if (b0 == BOM8_FIRST && b1 == BOM8_SEC && b2 == BOM8_THIRD)
			g = GUESS_UTF8;
		else
			g = GUESS_CP1252;
		return g;
	endfunction

endpackage

// ===== rtl/kbd_front.sv =====
// Front end: accepts scrambled items, keeps key and position counters, descrambles.
// Depends on kbd_pkg; pushes into kbd_queue.
`timescale 1ns / 1ps

module kbd_front import kbd_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      scr_valid,
	output logic      scr_stall,
	input  in_item_t  scr_item,
	input  q_status_t q_status,
	output logic      push,
	output q_entry_t  push_entry
);

	logic [KEY_IDX_W-1:0] key_index_q;
	logic [2:0]           mod_five_q;
	logic [2:0]           mod_seven_q;
	logic [1:0]           mod_three_q;
	logic [7:0]           b0, b1, b2, b3;

	assign scr_stall = q_status.full;
	assign push      = scr_valid && !q_status.full;

	always_comb begin
		b0 = scr_item.data_byte + ADD_BIAS - key_byte(key_index_q);
		b1 = (mod_five_q != 3'd0) ? b0 + STEP_FIVE : b0;
		b2 = (mod_seven_q != 3'd0) ? b1 - STEP_SEVEN : b1;
		b3 = (mod_three_q != 2'd0) ? b2 + STEP_THREE : b2;
		push_entry.plain = ~b3 - FINAL_SUB;
		push_entry.last  = scr_item.last_byte;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_index_q <= '0;
			mod_five_q  <= '0;
			mod_seven_q <= '0;
			mod_three_q <= '0;
		end else if (push) begin
			if (scr_item.last_byte) begin
				key_index_q <= '0;
				mod_five_q  <= '0;
				mod_seven_q <= '0;
				mod_three_q <= '0;
			end else begin
				key_index_q <= (key_index_q == KEY_IDX_W'(KEY_LENGTH - 1)) ? '0 :
					key_index_q + 1'b1;
				mod_five_q  <= (mod_five_q == 3'd4) ? 3'd0 : mod_five_q + 3'd1;
				mod_seven_q <= (mod_seven_q == 3'd6) ? 3'd0 : mod_seven_q + 3'd1;
				mod_three_q <= (mod_three_q == 2'd2) ? 2'd0 : mod_three_q + 2'd1;
			end
		end
	end

	property p_mod_ranges;
		@(posedge clk) disable iff (!arst_n)
		mod_five_q <= 3'd4 && mod_seven_q <= 3'd6 && mod_three_q <= 2'd2;
	endproperty
	a_mod_ranges: assert property (p_mod_ranges) else $error("position counter out of range");

	property p_last_clears;
		@(posedge clk) disable iff (!arst_n)
		push && scr_item.last_byte |=> key_index_q == '0 && mod_five_q == 3'd0;
	endproperty
	a_last_clears: assert property (p_last_clears) else $error("counters not cleared at file end");

endmodule

// ===== rtl/kbd_queue.sv =====
// Two-entry queue of descrambled bytes between front and back end.
// Depends on kbd_pkg.
`timescale 1ns / 1ps

module kbd_queue import kbd_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      push,
	input  q_entry_t  push_entry,
	input  logic      pop,
	output q_entry_t  head,
	output q_status_t status
);

	q_entry_t          mem_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] count_q;

	assign head         = mem_q[rd_ptr_q];
	assign status.full  = (count_q == QCNT_W'(QUEUE_DEPTH));
	assign status.empty = (count_q == '0);

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_ptr_q] <= push_entry;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push)
				wr_ptr_q <= (wr_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			if (pop)
				rd_ptr_q <= (rd_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			if (push && !pop)
				count_q <= count_q + 1'b1;
			else if (pop && !push)
				count_q <= count_q - 1'b1;
		end
	end

	property p_no_overflow;
		@(posedge clk) disable iff (!arst_n)
		push |-> !status.full;
	endproperty
	a_no_overflow: assert property (p_no_overflow) else $error("push into full queue");

	property p_no_underflow;
		@(posedge clk) disable iff (!arst_n)
		pop |-> !status.empty;
	endproperty
	a_no_underflow: assert property (p_no_underflow) else $error("pop from empty queue");

endmodule

// ===== rtl/kbd_back.sv =====
// Back end: pops descrambled bytes, forms the encoding guess, holds the result register.
// Depends on kbd_pkg; reads from kbd_queue.
`timescale 1ns / 1ps

module kbd_back import kbd_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  q_entry_t  head,
	input  q_status_t q_status,
	output logic      pop,
	output logic      pln_valid,
	input  logic      pln_stall,
	output out_item_t pln_item
);

	logic [1:0] bytes_seen_q;
	logic [7:0] first_q;
	logic [7:0] second_q;
	guess_t     held_guess_q;
	guess_t     guess;
	logic       out_valid_q;
	out_item_t  out_q;

	assign pop       = !q_status.empty && (!out_valid_q || !pln_stall);
	assign pln_valid = out_valid_q;
	assign pln_item  = out_q;

	always_comb begin
		unique case (bytes_seen_q)
			2'd0:    guess = guess_of(head.plain, 8'd0, 8'd0);
			2'd1:    guess = guess_of(first_q, head.plain, 8'd0);
			2'd2:    guess = guess_of(first_q, second_q, head.plain);
			default: guess = held_guess_q;
		endcase
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			out_q.plain_byte     <= head.plain;
			out_q.encoding_guess <= guess;
			out_q.guess_final    <= bytes_seen_q[1] || head.last;
			out_q.last_out       <= head.last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			bytes_seen_q <= '0;
			first_q      <= '0;
			second_q     <= '0;
			held_guess_q <= GUESS_CP1252;
		end else begin
			if (pop)
				out_valid_q <= 1'b1;
			else if (!pln_stall)
				out_valid_q <= 1'b0;
			if (pop) begin
				if (head.last) begin
					bytes_seen_q <= '0;
					first_q      <= '0;
					second_q     <= '0;
					held_guess_q <= GUESS_CP1252;
				end else begin
					unique case (bytes_seen_q)
						2'd0:    first_q      <= head.plain;
						2'd1:    second_q     <= head.plain;
						2'd2:    held_guess_q <= guess;
						default: ;
					endcase
					if (bytes_seen_q != 2'd3)
						bytes_seen_q <= bytes_seen_q + 2'd1;
				end
			end
		end
	end

	property p_pop_loads;
		@(posedge clk) disable iff (!arst_n)
		pop |=> out_valid_q;
	endproperty
	a_pop_loads: assert property (p_pop_loads) else $error("popped item not presented");

	property p_final_after_two;
		@(posedge clk) disable iff (!arst_n)
		pop && bytes_seen_q[1] |=> out_q.guess_final;
	endproperty
	a_final_after_two: assert property (p_final_after_two) else $error("guess not final");

endmodule

// ===== rtl/keyed_byte_descrambler.sv =====
// Top level of the keyed byte descrambler: front end, queue, back end.
// Depends on kbd_pkg, kbd_front, kbd_queue and kbd_back.
//
// Usage:
//   scr_valid/scr_stall/scr_item carry scrambled bytes in file order; last_byte
//   marks the final byte of a file. pln_valid/pln_stall/pln_item return one
//   descrambled item per input item, in order, with the encoding guess taken
//   from the first three plain bytes of the file.
//   Path: an accepted item is written into the queue and presented from the
//   result register. Throughput, while pln_stall is low: one item per cycle;
//   the front end, two-entry queue and back-end result register each take one per cycle.
//   Stall: while pln_stall is high the result register holds; the queue
//   absorbs two more items, then scr_stall rises until the back end drains.
//   Reset: arst_n clears the key index, position counters, saved bytes and
//   queue; no result is valid after reset. A file end clears the key index,
//   position counters and saved bytes for the next file.
`timescale 1ns / 1ps

module keyed_byte_descrambler import kbd_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      scr_valid,
	output logic      scr_stall,
	input  in_item_t  scr_item,
	output logic      pln_valid,
	input  logic      pln_stall,
	output out_item_t pln_item
);

	logic      push;
	logic      pop;
	q_entry_t  push_entry;
	q_entry_t  head;
	q_status_t q_status;

	kbd_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.scr_valid  (scr_valid),
		.scr_stall  (scr_stall),
		.scr_item   (scr_item),
		.q_status   (q_status),
		.push       (push),
		.push_entry (push_entry)
	);

	kbd_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_entry (push_entry),
		.pop        (pop),
		.head       (head),
		.status     (q_status)
	);

	kbd_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.head      (head),
		.q_status  (q_status),
		.pop       (pop),
		.pln_valid (pln_valid),
		.pln_stall (pln_stall),
		.pln_item  (pln_item)
	);

endmodule

// ===== test/tb_top.sv =====
// Testbench for keyed_byte_descrambler: directed table, then random files, some with BOM prefixes.
// Checks plain items against a local model or typed directed rows; depends on kbd_pkg and the RTL.
`timescale 1ns / 1ps

module tb_top;
	import kbd_pkg::*;

	typedef struct packed {
		logic [7:0] data;
		logic       last;
		bit         typed;
		out_item_t  want;
	} dir_row_t;

	localparam logic [7:0] SCR_KEY [32] = '{
		8'd66, 8'd67, 8'd51, 8'd55, 8'd51, 8'd65, 8'd67, 8'd65,
		8'd50, 8'd55, 8'd57, 8'd50, 8'd52, 8'd69, 8'd66, 8'd69,
		8'd65, 8'd50, 8'd57, 8'd68, 8'd50, 8'd65, 8'd50, 8'd50,
		8'd69, 8'd51, 8'd52, 8'd56, 8'd65, 8'd67, 8'd66, 8'd52
	};

	// data 189/195 give plain 255/254 at positions 0/1; 205/6/242 give 239/187/191
	localparam dir_row_t DIRECTED [25] = '{
		'{8'd0,   1'b1, 1'b1, '{8'd188, GUESS_CP1252, 1'b1, 1'b1}},
		'{8'd255, 1'b1, 1'b1, '{8'd189, GUESS_CP1252, 1'b1, 1'b1}},
		'{8'd189, 1'b1, 1'b1, '{8'd255, GUESS_CP1252, 1'b1, 1'b1}},
		'{8'd189, 1'b0, 1'b1, '{8'd255, GUESS_CP1252, 1'b0, 1'b0}},
		'{8'd195, 1'b1, 1'b1, '{8'd254, GUESS_UTF16, 1'b1, 1'b1}},
		'{8'd189, 1'b0, 1'b0, '0},
		'{8'd195, 1'b0, 1'b0, '0},
		'{8'd0,   1'b0, 1'b0, '0},
		'{8'd255, 1'b0, 1'b0, '0},
		'{8'd128, 1'b1, 1'b0, '0},
		'{8'd205, 1'b0, 1'b1, '{8'd239, GUESS_CP1252, 1'b0, 1'b0}},
		'{8'd6,   1'b0, 1'b0, '0},
		'{8'd242, 1'b0, 1'b0, '0},
		'{8'd0,   1'b0, 1'b0, '0},
		'{8'd255, 1'b1, 1'b0, '0},
		'{8'd205, 1'b0, 1'b0, '0},
		'{8'd6,   1'b0, 1'b0, '0},
		'{8'd243, 1'b1, 1'b0, '0},
		'{8'd205, 1'b0, 1'b0, '0},
		'{8'd7,   1'b0, 1'b0, '0},
		'{8'd242, 1'b1, 1'b0, '0},
		'{8'd255, 1'b0, 1'b0, '0},
		'{8'd0,   1'b0, 1'b0, '0},
		'{8'd128, 1'b0, 1'b0, '0},
		'{8'd127, 1'b1, 1'b0, '0}
	};

	logic      clk;
	logic      arst_n;
	logic      scr_valid;
	logic      scr_stall;
	in_item_t  scr_item;
	logic      pln_valid;
	logic      pln_stall;
	out_item_t pln_item;

	logic [KEY_IDX_W-1:0] key_pos;
	logic [2:0]           pos_mod5;
	logic [2:0]           pos_mod7;
	logic [1:0]           pos_mod3;
	logic [7:0]           saved_first;
	logic [7:0]           saved_second;
	logic [1:0]           seen_count;
	guess_t               held_guess;

	out_item_t pending_plain [$];
	int        mismatch_count;
	int        random_sent;
	bit        tx_idle_on;
	bit        rx_idle_on;
	int        stall_left;

	keyed_byte_descrambler DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.scr_valid (scr_valid),
		.scr_stall (scr_stall),
		.scr_item  (scr_item),
		.pln_valid (pln_valid),
		.pln_stall (pln_stall),
		.pln_item  (pln_item)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#5_000_000;
		$display("tb_top: errors");
		$finish;
	end

	function automatic void clear_file_state();
		key_pos      = '0;
		pos_mod5     = '0;
		pos_mod7     = '0;
		pos_mod3     = '0;
		saved_first  = '0;
		saved_second = '0;
		seen_count   = '0;
		held_guess   = GUESS_CP1252;
	endfunction

	function automatic guess_t bom_guess(input logic [7:0] b0, input logic [7:0] b1,
			input logic [7:0] b2);
		if (b0 == 8'd255 && b1 == 8'd254)
			return GUESS_UTF16;
		if (b0 == 8'd239 && b1 == 8'd187 && b2 == 8'd191)
			return GUESS_UTF8;
		return GUESS_CP1252;
	endfunction

	// one descrambled item; advances the file state
	function automatic out_item_t descramble_step(input logic [7:0] data, input logic last);
		out_item_t res;
		logic [7:0] b;
		guess_t g;
		b = data + 8'd106 - SCR_KEY[key_pos % 32];
		if (pos_mod5 != 0)
			b = b + 8'd2;
		if (pos_mod7 != 0)
			b = b - 8'd9;
		if (pos_mod3 != 0)
			b = b + 8'd3;
		b = ~b;
		res.plain_byte = b - 8'd27;
		case (seen_count)
			2'd0: g = bom_guess(res.plain_byte, 8'd0, 8'd0);
			2'd1: g = bom_guess(saved_first, res.plain_byte, 8'd0);
			2'd2: g = bom_guess(saved_first, saved_second, res.plain_byte);
			default: g = held_guess;
		endcase
		res.encoding_guess = g;
		res.guess_final = (seen_count >= 2'd2) || last;
		res.last_out = last;
		if (last) begin
			clear_file_state();
		end else begin
			case (seen_count)
				2'd0: saved_first = res.plain_byte;
				2'd1: saved_second = res.plain_byte;
				2'd2: held_guess = g;
				default: ;
			endcase
			if (seen_count != 2'd3)
				seen_count = seen_count + 2'd1;
			key_pos  = (key_pos == KEY_LENGTH - 1) ? '0 : key_pos + 1'b1;
			pos_mod5 = (pos_mod5 == 3'd4) ? 3'd0 : pos_mod5 + 3'd1;
			pos_mod7 = (pos_mod7 == 3'd6) ? 3'd0 : pos_mod7 + 3'd1;
			pos_mod3 = (pos_mod3 == 2'd2) ? 2'd0 : pos_mod3 + 2'd1;
		end
		return res;
	endfunction

	// scrambled byte that yields the given plain byte at the current position
	function automatic logic [7:0] scramble_for(input logic [7:0] plain);
		logic [7:0] b;
		b = plain + 8'd27;
		b = ~b;
		if (pos_mod3 != 0)
			b = b - 8'd3;
		if (pos_mod7 != 0)
			b = b + 8'd9;
		if (pos_mod5 != 0)
			b = b - 8'd2;
		return b - 8'd106 + SCR_KEY[key_pos % 32];
	endfunction

	task automatic report_error(input string msg);
		$display("ERROR at %0t: %s", $time, msg);
		mismatch_count++;
	endtask

	task automatic check_field(input string name, input int got, input int want);
		if (got != want)
			report_error($sformatf("%s got %0d, want %0d", name, got, want));
	endtask

	task automatic push_byte(input logic [7:0] data, input logic last, input bit typed,
			input out_item_t typed_want);
		out_item_t predicted;
		@(negedge clk);
		if (tx_idle_on && $urandom_range(0, 3) == 0) begin
			scr_valid <= 1'b0;
			repeat ($urandom_range(1, 17)) @(negedge clk);
		end
		scr_valid <= 1'b1;
		scr_item  <= '{data_byte: data, last_byte: last};
		@(posedge clk);
		while (scr_stall)
			@(posedge clk);
		predicted = descramble_step(data, last);
		pending_plain.push_back(typed ? typed_want : predicted);
	endtask

	task automatic drain_results();
		@(negedge clk);
		scr_valid <= 1'b0;
		while (pending_plain.size() != 0)
			@(posedge clk);
	endtask

	task automatic send_file(input int len, input int kind);
		logic [7:0] prefix [$];
		logic [7:0] data;
		int k;
		case (kind)
			1: prefix = '{8'd255, 8'd254};
			2: prefix = '{8'd239, 8'd187, 8'd191};
			3: begin
				prefix = '{8'd239, 8'd187, 8'd191};
				k = $urandom_range(0, 2);
				prefix[k] = prefix[k] ^ 8'($urandom_range(1, 255));
			end
			4: prefix = '{8'd255, 8'($urandom_range(0, 255))};
			default: ;
		endcase
		for (int i = 0; i < len; i++) begin
			if (i < prefix.size())
				data = scramble_for(prefix[i]);
			else
				data = 8'($urandom_range(0, 255));
			push_byte(data, i == len - 1, 1'b0, '0);
			random_sent++;
		end
	endtask

	initial begin
		stall_left = 0;
		pln_stall  = 1'b0;
		forever begin
			@(negedge clk);
			if (stall_left > 0) begin
				stall_left--;
				pln_stall <= 1'b1;
			end else if (rx_idle_on && $urandom_range(0, 5) == 0) begin
				stall_left = $urandom_range(0, 16);
				pln_stall <= 1'b1;
			end else begin
				pln_stall <= 1'b0;
			end
		end
	end

	always @(posedge clk) begin : plain_monitor
		out_item_t want;
		if (arst_n && pln_valid && !pln_stall) begin
			if (pending_plain.size() == 0) begin
				report_error("plain item with none expected");
			end else begin
				want = pending_plain.pop_front();
				check_field("plain_byte", pln_item.plain_byte, want.plain_byte);
				check_field("encoding_guess", pln_item.encoding_guess, want.encoding_guess);
				check_field("guess_final", pln_item.guess_final, want.guess_final);
				check_field("last_out", pln_item.last_out, want.last_out);
			end
		end
	end

	initial begin
		int len;
		int sel;
		arst_n         = 1'b0;
		scr_valid      = 1'b0;
		scr_item       = '0;
		mismatch_count = 0;
		random_sent    = 0;
		tx_idle_on     = 1'b1;
		rx_idle_on     = 1'b1;
		clear_file_state();
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		foreach (DIRECTED[i])
			push_byte(DIRECTED[i].data, DIRECTED[i].last, DIRECTED[i].typed, DIRECTED[i].want);
		drain_results();

		while (random_sent < 2000) begin
			tx_idle_on = (random_sent < 1800) && ($urandom_range(0, 3) != 0);
			rx_idle_on = (random_sent < 1800) && ($urandom_range(0, 3) != 0);
			sel = $urandom_range(0, 99);
			if (sel < 70)
				len = $urandom_range(1, 8);
			else if (sel < 95)
				len = $urandom_range(9, 40);
			else
				len = $urandom_range(41, 120);
			send_file(len, $urandom_range(0, 5));
			if ($urandom_range(0, 19) == 0)
				drain_results();
		end

		@(negedge clk);
		scr_valid <= 1'b0;
		drain_results();
		repeat (4) @(posedge clk);
		if (mismatch_count == 0)
			$display("tb_top: clean");
		else
			$display("tb_top: errors");
		$finish;
	end

endmodule
